// ===== design/weekly_alarm_table_matcher_core_assert.svh =====
// Assertion macros shared by the alarm table matcher modules.
`ifndef WEEKLY_ALARM_TABLE_MATCHER_CORE_ASSERT_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WATM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WATM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/watm_pkg.sv =====
// Types and constants for the weekly alarm table matcher.
`default_nettype none

package watm_pkg;

  // Request kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Insert status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_CONFLICT = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  // Weekday code that wraps to Sunday
  localparam logic [2:0] WEEKDAY_SUNDAY_ALT = 3'd7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // One stored alarm
  typedef struct packed {
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] tag;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_end;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/watm_dpath.sv =====
// Datapath: request registers, alarm memory, scan compare and result register.
`default_nettype none

`include "weekly_alarm_table_matcher_core_assert.svh"

module watm_dpath #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = 4,
  parameter int CNT_W         = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire watm_pkg::cmd_t  cmd,
  output watm_pkg::sts_t       sts,
  input  wire logic [1:0]      in_kind,
  input  wire logic [6:0]      in_day_mask,
  input  wire logic [4:0]      in_alarm_hour,
  input  wire logic [5:0]      in_alarm_minute,
  input  wire logic [7:0]      in_event_tag,
  input  wire logic [2:0]      in_now_weekday,
  input  wire logic [4:0]      in_now_hour,
  input  wire logic [5:0]      in_now_minute,
  input  wire logic [5:0]      in_now_second,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  output logic [1:0]           out_insert_status,
  output logic                 out_matched,
  output logic                 out_fired,
  output logic [7:0]           out_match_tag,
  output logic [3:0]           out_match_slot
);

  // Latched request
  logic [1:0]       kind_r;
  logic [6:0]       mask_r;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [7:0]       tag_r;

  // Control state
  logic             enable_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_addr_r;
  logic             cmp_valid_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_slot_r;
  logic [7:0]       hit_tag_r;

  // Memory
  watm_pkg::entry_t mem [TABLE_ENTRIES];
  watm_pkg::entry_t rd_data_r;

  logic [2:0]       wd_fix;
  logic [6:0]       day_bit;
  logic             issue;
  logic             hit;
  logic             full;
  logic             wr_en;
  logic [IDX_W+3:0] slot_ext;

  // Weekday to day-mask bit, seven wraps to Sunday
  assign wd_fix  = (in_now_weekday == watm_pkg::WEEKDAY_SUNDAY_ALT) ? 3'd0 : in_now_weekday;
  assign day_bit = 7'd1 << wd_fix;

  assign sts.needs_scan = (in_kind == watm_pkg::KIND_INSERT) ||
                          ((in_kind == watm_pkg::KIND_TICK) && (in_now_second == 6'd0));

  // Scan issue and compare stage
  assign issue = cmd.scan && (rd_addr_r < count_r);
  assign hit   = cmp_valid_r && ((rd_data_r.days & mask_r) != 7'd0) &&
                 (rd_data_r.hour == hour_r) && (rd_data_r.minute == minute_r);
  assign sts.scan_end = hit || (!issue && !cmp_valid_r);

  assign full  = (count_r == CNT_W'(TABLE_ENTRIES));
  assign wr_en = cmd.finish && (kind_r == watm_pkg::KIND_INSERT) && !hit_r && !full;

  assign slot_ext = {4'd0, hit_slot_r};

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r   <= in_kind;
      tag_r    <= in_event_tag;
      if (in_kind == watm_pkg::KIND_TICK) begin
        mask_r   <= day_bit;
        hour_r   <= in_now_hour;
        minute_r <= in_now_minute;
      end else begin
        mask_r   <= in_day_mask;
        hour_r   <= in_alarm_hour;
        minute_r <= in_alarm_minute;
      end
    end
  end

  // Alarm memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= '{days: mask_r, hour: hour_r, minute: minute_r, tag: tag_r};
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr_r[IDX_W-1:0]];
    end
  end

  // Scan control, hit capture, fill count and enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      count_r     <= '0;
      rd_addr_r   <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        rd_addr_r   <= '0;
        cmp_valid_r <= 1'b0;
        hit_r       <= 1'b0;
      end else begin
        cmp_valid_r <= issue;
        if (issue) begin
          rd_addr_r <= rd_addr_r + CNT_W'(1);
        end
        if (cmd.scan && hit) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.finish && (kind_r == watm_pkg::KIND_CLEAR)) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Hit payload
  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx_r <= rd_addr_r[IDX_W-1:0];
    end
    if (cmd.scan && hit) begin
      hit_slot_r <= cmp_idx_r;
      hit_tag_r  <= rd_data_r.tag;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_insert_status <= watm_pkg::STAT_NONE;
      out_matched       <= 1'b0;
      out_fired         <= 1'b0;
      out_match_tag     <= 8'd0;
      out_match_slot    <= 4'd0;
      case (kind_r)
        watm_pkg::KIND_INSERT: begin
          if (hit_r) begin
            out_insert_status <= watm_pkg::STAT_CONFLICT;
          end else if (full) begin
            out_insert_status <= watm_pkg::STAT_FULL;
          end else begin
            out_insert_status <= watm_pkg::STAT_OK;
          end
        end
        watm_pkg::KIND_TICK: begin
          if (hit_r) begin
            out_matched    <= 1'b1;
            out_fired      <= enable_r;
            out_match_tag  <= hit_tag_r;
            out_match_slot <= slot_ext[3:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  `WATM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_ENTRIES), "fill count overflow")
  `WATM_ASSERT_NEXT(a_clear_empties, cmd.finish && (kind_r == watm_pkg::KIND_CLEAR), count_r == '0, "clear left entries")
  `WATM_ASSERT_NOW(a_scan_no_stale_hit, cmd.scan, !hit_r, "scan running after a hit")

endmodule

`default_nettype wire

// ===== design/watm_ctrl.sv =====
// Controller: accept, scan and result handoff sequencing.
`default_nettype none

`include "weekly_alarm_table_matcher_core_assert.svh"

module watm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output watm_pkg::cmd_t       cmd,
  input  wire watm_pkg::sts_t  sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  assign cmd.start  = in_tvalid && in_tready;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.finish = (state_r == ST_DONE) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = sts.needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WATM_ASSERT_NEXT(a_start_busy, cmd.start, state_r != ST_IDLE, "accepted request left idle")
  `WATM_ASSERT_NEXT(a_scan_to_done, cmd.scan && sts.scan_end, state_r == ST_DONE, "scan end lost")
  `WATM_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r, "result not presented")

endmodule

`default_nettype wire

// ===== design/weekly_alarm_table_matcher_core.sv =====
// Weekly alarm table matcher: up to TABLE_ENTRIES alarms, one request at a time.
// Clears, unused kinds and ticks off second zero go from accept straight to the result register;
// inserts and ticks on second zero first scan the entries in use, one entry per cycle through
// the single read port of the alarm memory; a result not yet taken stalls the handoff to the output.
// A new request is accepted only after the previous result has been loaded for output.
// Reset (rst_n low, synchronous): table empty, scheduler disabled, no result pending.
`default_nettype none

module weekly_alarm_table_matcher_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // day_mask[6:0], alarm_hour[11:7], alarm_minute[17:12], event_tag[25:18],
  // now_weekday[28:26], now_hour[33:29], now_minute[39:34], now_second[45:40]
  input  wire logic [watm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  wire logic [1:0]                        in_tuser,
  // Result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // insert_status[1:0], matched[2], fired[3], match_tag[11:4], match_slot[15:12]
  output logic [watm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // Configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_wr_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  watm_pkg::cmd_t cmd;
  watm_pkg::sts_t sts;

  logic [1:0] res_status;
  logic       res_matched;
  logic       res_fired;
  logic [7:0] res_tag;
  logic [3:0] res_slot;

  watm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  watm_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_tuser),
    .in_day_mask       (in_tdata[6:0]),
    .in_alarm_hour     (in_tdata[11:7]),
    .in_alarm_minute   (in_tdata[17:12]),
    .in_event_tag      (in_tdata[25:18]),
    .in_now_weekday    (in_tdata[28:26]),
    .in_now_hour       (in_tdata[33:29]),
    .in_now_minute     (in_tdata[39:34]),
    .in_now_second     (in_tdata[45:40]),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_insert_status (res_status),
    .out_matched       (res_matched),
    .out_fired         (res_fired),
    .out_match_tag     (res_tag),
    .out_match_slot    (res_slot)
  );

  // Pack the result
  assign out_tdata = {res_slot, res_tag, res_fired, res_matched, res_status};

endmodule

`default_nettype wire
